// ===== src/sha384_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-384 package
// Shared types, constants and round functions for the SHA-384 hash core.
// ----------------------------------------------------------------------------
package sha384_pkg;

  typedef logic [63:0] word_t;

  // Word kinds passed from the front end to the compression engine
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_LAST = 2'd1;

  typedef struct packed {
    word_t      data;
    logic [1:0] kind;
  } qent_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [3:0]  WORD_BYTES  = 4'd8;
  localparam logic [3:0]  LEN_HI_SLOT = 4'd14;
  localparam int          ROUNDS      = 80;

  localparam word_t INIT_HASH [8] = '{
    64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17,
    64'h152FECD8F70E5939, 64'h67332667FFC00B31, 64'h8EB44A8768581511,
    64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4};

  localparam word_t ROUND_K [80] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
    64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
    64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
    64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
    64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
    64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
    64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
    64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
    64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
    64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
    64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
    64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
    64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
    64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t big_s0(word_t x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t big_s1(word_t x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t small_s0(word_t x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t small_s1(word_t x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

// ===== src/sha384_front.sv =====
// ----------------------------------------------------------------------------
// SHA-384 front end
// Accepts message words, masks the final word and pushes data words into the
// word queue; marks the last word of the message for the engine.
// ----------------------------------------------------------------------------
module sha384_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [63:0]             message_word,
  input  logic [3:0]              valid_bytes,
  input  logic                    end_of_message,
  output logic                    q_valid,
  input  logic                    q_ready,
  output sha384_pkg::qent_t       q_data,
  output logic [3:0]              q_nb
);

  sha384_pkg::qent_t        mem [sha384_pkg::QDEPTH];
  logic [sha384_pkg::QAW:0] wr_ptr;
  logic [sha384_pkg::QAW:0] rd_ptr;
  logic                     full;
  logic                     push;
  logic                     pop;
  logic [3:0]               nb;
  logic [63:0]              keep;
  sha384_pkg::qent_t        ent;

  assign full     = (wr_ptr[sha384_pkg::QAW] != rd_ptr[sha384_pkg::QAW]) &&
                    (wr_ptr[sha384_pkg::QAW-1:0] == rd_ptr[sha384_pkg::QAW-1:0]);
  assign in_ready = !full;
  assign push     = in_valid && in_ready;
  assign q_valid  = (wr_ptr != rd_ptr);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem[rd_ptr[sha384_pkg::QAW-1:0]];

  // classify: clamp the byte count and clear unused bytes of the final word
  always_comb begin
    nb   = (valid_bytes > sha384_pkg::WORD_BYTES) ? sha384_pkg::WORD_BYTES : valid_bytes;
    keep = (nb == 4'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> {nb, 3'b000});
    ent.kind = end_of_message ? sha384_pkg::KIND_LAST : sha384_pkg::KIND_DATA;
    ent.data = end_of_message ? (message_word & keep) : message_word;
  end

  // byte count of the final word travels in a small side queue
  logic [3:0] nb_mem [sha384_pkg::QDEPTH];
  assign q_nb = nb_mem[rd_ptr[sha384_pkg::QAW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr[sha384_pkg::QAW-1:0]]    <= ent;
      nb_mem[wr_ptr[sha384_pkg::QAW-1:0]] <= nb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
    end
  end

endmodule

// ===== src/sha384_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-384 compression engine
// Builds blocks, pads the final block, runs 80 rounds one per cycle and
// streams out the six digest words straight from the hash registers.
// ----------------------------------------------------------------------------
module sha384_engine (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  sha384_pkg::qent_t       q_data,
  input  logic [3:0]              q_nb,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [63:0]             digest_word,
  output logic [2:0]              word_index,
  output logic                    last_word
);

  localparam logic [2:0] ST_FILL  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]              state;
  sha384_pkg::word_t       w [16];
  sha384_pkg::word_t       h [8];
  sha384_pkg::word_t       v [8];
  logic [4:0]              fill;
  logic [6:0]              rnd;
  logic [63:0]             cnt_lo;
  logic [63:0]             cnt_hi;
  logic                    final_blk;   // this block ends the message
  logic                    padding;     // pad words being generated
  logic [2:0]              oidx;

  // words into the block: from queue or from the pad generator
  logic                    take;
  sha384_pkg::word_t       win;
  logic                    win_ok;
  logic                    pad80;       // a full last word still needs the 0x80 word
  logic [63:0]             add_n;
  logic [63:0]             lo_next;
  logic [63:0]             hi_next;

  assign q_ready = (state == ST_FILL) && !padding;
  assign take    = q_valid && q_ready;

  always_comb begin
    add_n = (q_data.kind == sha384_pkg::KIND_LAST) ? {60'd0, q_nb} : 64'd8;
    lo_next = cnt_lo + add_n;
    hi_next = cnt_hi + {63'd0, (lo_next < add_n)};
    win_ok = 1'b0;
    win    = '0;
    if (take) begin
      win_ok = 1'b1;
      win    = q_data.data;
      if (q_data.kind == sha384_pkg::KIND_LAST && q_nb != sha384_pkg::WORD_BYTES)
        win = q_data.data | ({56'd0, sha384_pkg::PAD_BYTE} << (7'd56 - {q_nb[2:0], 3'b000}));
    end else if (state == ST_FILL && padding) begin
      win_ok = 1'b1;
      if (pad80)                                win = {sha384_pkg::PAD_BYTE, 56'd0};
      else if (final_blk && fill[3:0] == sha384_pkg::LEN_HI_SLOT)
        win = {cnt_hi[60:0], cnt_lo[63:61]};
      else if (final_blk && fill[3:0] == 4'd15) win = {cnt_lo[60:0], 3'b000};
      else                                      win = '0;
    end
  end

  // schedule word and round datapath
  sha384_pkg::word_t wt, t1, t2;
  always_comb begin
    if (rnd < 7'd16) wt = w[rnd[3:0]];
    else wt = sha384_pkg::small_s1(w[14]) + w[9] + sha384_pkg::small_s0(w[1]) + w[0];
    t1 = v[7] + sha384_pkg::big_s1(v[4]) + (v[6] ^ (v[4] & (v[5] ^ v[6]))) +
         sha384_pkg::ROUND_K[rnd] + wt;
    t2 = sha384_pkg::big_s0(v[0]) + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
  end

  assign out_valid   = (state == ST_OUT);
  assign digest_word = h[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd5);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      fill      <= '0;
      rnd       <= '0;
      cnt_lo    <= '0;
      cnt_hi    <= '0;
      final_blk <= 1'b0;
      padding   <= 1'b0;
      pad80     <= 1'b0;
      oidx      <= '0;
      for (int i = 0; i < 8; i++) h[i] <= sha384_pkg::INIT_HASH[i];
    end else begin
      unique case (state)
        ST_FILL, ST_PAD: begin
          if (take) begin
            cnt_lo <= lo_next;
            cnt_hi <= hi_next;
            if (q_data.kind == sha384_pkg::KIND_LAST) begin
              padding <= 1'b1;
              pad80   <= (q_nb == sha384_pkg::WORD_BYTES);
              // length fits after this word only if at most 14 words used
              final_blk <= (fill <= 5'd13) && (q_nb != sha384_pkg::WORD_BYTES) ||
                           (fill <= 5'd12);
            end
          end else if (win_ok) begin
            if (pad80) begin
              pad80     <= 1'b0;
              final_blk <= (fill <= 5'd13);
            end
          end
          if (win_ok) begin
            w[fill[3:0]] <= win;
            if (fill == 5'd15) begin
              fill  <= '0;
              rnd   <= '0;
              for (int i = 0; i < 8; i++) v[i] <= h[i];
              state <= ST_ROUND;
            end else begin
              fill <= fill + 5'd1;
            end
          end
        end
        ST_ROUND: begin
          if (rnd >= 7'd16) begin
            for (int i = 0; i < 15; i++) w[i] <= w[i+1];
            w[15] <= wt;
          end else if (rnd == 7'd15) begin
            // from here the window is rolled: w[0] is word t-16
          end
          // working variables shift down; e and a take the new sums
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          if (rnd == 7'(sha384_pkg::ROUNDS - 1)) state <= ST_ADD;
          rnd <= rnd + 7'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          if (padding && final_blk) begin
            oidx  <= '0;
            state <= ST_OUT;
          end else begin
            if (padding) final_blk <= 1'b1;
            state <= ST_FILL;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            if (oidx == 3'd5) begin
              state     <= ST_FILL;
              padding   <= 1'b0;
              final_blk <= 1'b0;
              cnt_lo    <= '0;
              cnt_hi    <= '0;
              for (int i = 0; i < 8; i++) h[i] <= sha384_pkg::INIT_HASH[i];
            end
            oidx <= oidx + 3'd1;
          end
        end
        default: state <= ST_FILL;
      endcase
    end
  end

endmodule

// ===== src/sha384_hash_core.sv =====
// ----------------------------------------------------------------------------
// SHA-384 hash core
// Streams a message in 64-bit words and returns the six digest words.
// ----------------------------------------------------------------------------
// Input: s_axis carries one message word per request; tlast marks the final
// word, tuser holds its valid byte count (0..8, most significant bytes
// first). Other words always count as eight bytes.
// Output: m_axis returns six digest words, first word first, tlast on the
// sixth, tuser giving the word position.
// A four-entry word queue separates the input from the compression engine,
// so input is taken while the engine runs. Each 16-word block is filled,
// run through 80 rounds and added into the hash; sustained input is set
// by the single round datapath. Padding may add a block.
// Digest words appear one per cycle after the last block; if the receiver
// stalls, the engine holds the current word. Reset restores the initial
// hash and clears the queue and counters.
// ----------------------------------------------------------------------------
module sha384_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // message_word
  input  logic [3:0]  s_axis_tuser,   // valid_bytes
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // word_index
  output logic        m_axis_tlast    // last_word
);

  logic              q_valid;
  logic              q_ready;
  sha384_pkg::qent_t q_data;
  logic [3:0]        q_nb;

  sha384_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .message_word(s_axis_tdata), .valid_bytes(s_axis_tuser),
    .end_of_message(s_axis_tlast),
    .q_valid, .q_ready, .q_data, .q_nb
  );

  sha384_engine u_engine (
    .clk, .rst,
    .q_valid, .q_ready, .q_data, .q_nb,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .digest_word(m_axis_tdata), .word_index(m_axis_tuser),
    .last_word(m_axis_tlast)
  );

endmodule

// ===== src/sha384_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-384 port checker
// Checks digest sequencing and output stall behavior at the top ports.
// ----------------------------------------------------------------------------
module sha384_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled digest word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("digest word changed under stall");

  // tlast exactly on position five
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd5)))
    else $error("tlast position");

  // positions advance one by one inside a digest
  a_seq: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1)
    else $error("digest word order");

endmodule

bind sha384_hash_core sha384_checker u_checker (.*);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// SHA-384 hash core testbench
// Streams messages of random length and content into the core, computes
// each digest with a behavioral SHA-384 model, and checks every digest word
// returned on the output stream under varying sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // message_word
  logic [3:0]  s_axis_tuser;   // valid_bytes
  logic        s_axis_tlast;   // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // digest_word
  logic [2:0]  m_axis_tuser;   // word_index
  logic        m_axis_tlast;   // last_word

  typedef struct {
    sha384_pkg::word_t digest_word;
    logic [2:0]        word_index;
    logic              last_word;
  } digest_t;

  // Predictor state
  sha384_pkg::word_t hash_q [8];
  sha384_pkg::word_t blk_q [16];
  logic [4:0]        fill_q;
  logic [63:0]       len_lo_q;
  logic [63:0]       len_hi_q;

  digest_t     digest_expect_q [$];
  int          mismatch_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_off_cycles;

  sha384_hash_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic sha384_pkg::word_t ror64(sha384_pkg::word_t x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // Round constants derived from the package table
  function automatic sha384_pkg::word_t round_const(int t);
    return sha384_pkg::ROUND_K[t];
  endfunction

  // Restart the hash for a new message
  task automatic hash_init();
    for (int i = 0; i < 8; i++) hash_q[i] = sha384_pkg::INIT_HASH[i];
    fill_q   = '0;
    len_lo_q = '0;
    len_hi_q = '0;
  endtask

  // One 80-round compression over the current block
  task automatic hash_block();
    sha384_pkg::word_t w [16];
    sha384_pkg::word_t v [8];
    sha384_pkg::word_t wt, t1, t2, a, b;
    for (int i = 0; i < 16; i++) w[i] = blk_q[i];
    for (int i = 0; i < 8; i++) v[i] = hash_q[i];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        a  = w[(t - 2) & 15];
        b  = w[(t - 15) & 15];
        wt = (ror64(a, 19) ^ ror64(a, 61) ^ (a >> 6)) + w[(t - 7) & 15]
           + (ror64(b, 1) ^ ror64(b, 8) ^ (b >> 7)) + w[t & 15];
        w[t & 15] = wt;
      end
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + round_const(t) + wt;
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
      for (int j = 7; j > 0; j--) v[j] = v[j - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] = hash_q[i] + v[i];
  endtask

  task automatic block_push(sha384_pkg::word_t w);
    blk_q[fill_q[3:0]] = w;
    fill_q = fill_q + 5'd1;
    if (fill_q >= 5'd16) begin
      hash_block();
      fill_q = '0;
    end
  endtask

  task automatic len_add(logic [63:0] n);
    len_lo_q = len_lo_q + n;
    if (len_lo_q < n) len_hi_q = len_hi_q + 64'd1;
  endtask

  // Predict the digest words caused by one accepted request
  task automatic hash_absorb(sha384_pkg::word_t msg, logic [3:0] nb_in, logic eom);
    int                nb;
    sha384_pkg::word_t keep;
    digest_t           d;
    if (!eom) begin
      len_add(64'd8);
      block_push(msg);
      return;
    end
    nb = (nb_in > 4'd8) ? 8 : int'(nb_in);
    len_add(64'(nb));
    if (nb == 8) begin
      block_push(msg);
      block_push(64'h80 << 56);
    end else begin
      keep = (nb == 0) ? '0 : ~64'd0 << (64 - 8 * nb);
      block_push((msg & keep) | (64'h80 << (56 - 8 * nb)));
    end
    if (fill_q > 5'd14) while (fill_q != 5'd0) block_push('0);
    while (fill_q < 5'd14) block_push('0);
    block_push((len_hi_q << 3) | (len_lo_q >> 61));
    block_push(len_lo_q << 3);
    for (int k = 0; k < 6; k++) begin
      d.digest_word = hash_q[k];
      d.word_index  = k[2:0];
      d.last_word   = (k == 5);
      digest_expect_q.push_back(d);
    end
    hash_init();
  endtask

  // Send one request, idling before it at the current rate
  task automatic send_word(sha384_pkg::word_t msg, logic [3:0] nb, logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= msg;
    s_axis_tuser  <= nb;
    s_axis_tlast  <= eom;
    do @(posedge clk); while (!s_axis_tready);
    hash_absorb(msg, nb, eom);
  endtask

  task automatic send_message(int n_words, logic [3:0] nb, bit rand_content);
    sha384_pkg::word_t w;
    for (int i = 0; i < n_words; i++) begin
      w = rand_content ? {$urandom, $urandom} : '0;
      send_word(w, (i == n_words - 1) ? nb : 4'($urandom_range(15)),
                i == n_words - 1);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (digest_expect_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  // Output checker
  always @(posedge clk) begin
    digest_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (digest_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected digest word %h", m_axis_tdata);
      end else begin
        e = digest_expect_q.pop_front();
        if (m_axis_tdata !== e.digest_word || m_axis_tuser !== e.word_index ||
            m_axis_tlast !== e.last_word) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                     e.digest_word, e.word_index, e.last_word,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
      end
    end
  end

  // Receiver ready, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready   <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Directed: empty message, tail byte counts, extremes, block boundaries
  task automatic test_directed();
    send_word('0, 4'd0, 1'b1);
    send_word({8'h61, 8'h62, 8'h63, 40'h0}, 4'd3, 1'b1);
    send_word('1, 4'd15, 1'b1);
    send_word('1, 4'd8, 1'b1);
    send_word(64'h0123456789ABCDEF, 4'd7, 1'b1);
    send_message(14, 4'd8, 1'b1);
    send_message(15, 4'd1, 1'b1);
    drain();
  endtask

  // Random messages; mostly short, some spanning several blocks
  task automatic test_random(int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(50, 17) : $urandom_range(16, 1);
      send_message(len, 4'($urandom_range(15)), $urandom_range(15) != 0);
      sent += len;
    end
    drain();
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_off_cycles = 400;
    send_message(20, 4'd5, 1'b1);
    send_message(3, 4'd8, 1'b1);
    drain();
  endtask

  initial begin
    rst             = 1'b1;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    s_axis_tlast    = 1'b0;
    m_axis_tready   = 1'b0;
    mismatch_cnt    = 0;
    hold_off_cycles = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    hash_init();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 24;
    recv_idle_pct = 81;
    test_directed();
    test_random(120);
    send_idle_pct = 81;
    recv_idle_pct = 24;
    test_random(110);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(80);

    if (mismatch_cnt == 0 && digest_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sha384_hash_core.f =====
src/sha384_pkg.sv
src/sha384_front.sv
src/sha384_engine.sv
src/sha384_hash_core.sv
src/sha384_checker.sv
sim/tb_top.sv
